// File: rtl/msp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multiplexed servo pulse generator.
// No dependencies; imported by every module of the block except msp_ram.
package msp_pkg;

    // Byte and output widths fixed by the interface
    localparam int ByteW   = 8;
    localparam int PulseW  = 24;
    localparam int CfgIdxW = 8;
    localparam int LevelExtW = 64;

    // Reset values
    localparam logic [ByteW-1:0] CenterPos       = 8'd187;
    localparam logic [ByteW-1:0] ArmMarkerRst    = 8'd11;
    localparam logic [ByteW-1:0] DisarmMarkerRst = 8'd22;

    // Item kinds
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_BYTE = 1'b1
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_ARM_MARKER    = 8'd0,
        REG_DISARM_MARKER = 8'd1
    } cfg_reg_t;

endpackage

// File: rtl/msp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read (read returns old data on collision)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/msp_loader.sv
`timescale 1ns / 1ps
// Byte loader: marker decode, armed flag and position write index.
// Depends on msp_pkg.
module msp_loader #(
    parameter int SERVO_COUNT = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            byte_fire,
    input  logic [msp_pkg::ByteW-1:0]       data_byte,
    input  logic [msp_pkg::ByteW-1:0]       arm_marker,
    input  logic [msp_pkg::ByteW-1:0]       disarm_marker,
    output logic                            wr_en,
    output logic [$clog2(SERVO_COUNT)-1:0]  wr_addr,
    output logic [msp_pkg::ByteW-1:0]       wr_data,
    output logic                            stored
);
    import msp_pkg::*;

    localparam int AW = $clog2(SERVO_COUNT);
    localparam logic [AW-1:0] LastIdx = AW'(SERVO_COUNT - 1);

    logic          armed_reg, armed_next;
    logic [AW-1:0] widx_reg, widx_next;
    logic          is_arm, is_disarm;

    assign is_arm    = (data_byte == arm_marker);
    assign is_disarm = (data_byte == disarm_marker);

    // Disarm applies first, arm second; other bytes store while armed
    always_comb
    begin
        armed_next = armed_reg;
        widx_next  = widx_reg;
        stored     = 1'b0;
        if (byte_fire)
        begin
            if (is_disarm)
            begin
                armed_next = 1'b0;
                widx_next  = '0;
            end
            if (is_arm)
            begin
                armed_next = 1'b1;
                widx_next  = '0;
            end
            if (!is_arm && !is_disarm && armed_reg)
            begin
                stored    = 1'b1;
                widx_next = (widx_reg == LastIdx) ? '0 : widx_reg + AW'(1);
            end
        end
    end

    assign wr_en   = stored;
    assign wr_addr = widx_reg;
    assign wr_data = data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            widx_reg  <= '0;
        end
        else
        begin
            armed_reg <= armed_next;
            widx_reg  <= widx_next;
        end
    end

    // Write index stays inside the position store
    a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
        widx_reg <= LastIdx)
        else $error("write index out of range");

    // A store only happens while armed, and never on a marker byte
    a_store_armed: assert property (@(posedge clk) disable iff (!rst_n)
        stored |-> (armed_reg && !is_arm && !is_disarm))
        else $error("store without arm or on marker");

    // A marker byte restarts the write index
    a_marker_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && (is_arm || is_disarm)) |=> (widx_reg == '0))
        else $error("marker did not restart write index");

endmodule

// File: rtl/msp_pulse.sv
`timescale 1ns / 1ps
// Pulse timer: position store, tick counter, slot, compares and pulse levels.
// Depends on msp_pkg and msp_ram.
module msp_pulse #(
    parameter int SERVO_COUNT = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick_fire,
    input  logic                            wr_en,
    input  logic [$clog2(SERVO_COUNT)-1:0]  wr_addr,
    input  logic [msp_pkg::ByteW-1:0]       wr_data,
    output logic [SERVO_COUNT-1:0]          levels_next
);
    import msp_pkg::*;

    localparam int AW   = $clog2(SERVO_COUNT);
    localparam int Half = SERVO_COUNT / 2;
    localparam int SW   = (Half > 1) ? $clog2(Half) : 1;
    localparam logic [SW-1:0] LastSlot = SW'(Half - 1);

    logic [ByteW-1:0]       tick_reg, tick_next;
    logic [SW-1:0]          slot_reg, slot_next;
    logic [ByteW-1:0]       cmp_a_reg, cmp_a_next;
    logic [ByteW-1:0]       cmp_b_reg, cmp_b_next;
    logic [SERVO_COUNT-1:0] levels_reg;
    logic [SERVO_COUNT-1:0] valid_reg;
    logic                   fwd_en_reg;
    logic [AW-1:0]          fwd_addr_reg;
    logic [ByteW-1:0]       fwd_data_reg;

    logic [AW-1:0]          addr_a, addr_b;
    logic [ByteW-1:0]       rd_a, rd_b;
    logic [ByteW-1:0]       pos_a, pos_b;
    logic [SERVO_COUNT-1:0] mask_a, mask_b, start_mask;

    // Addresses of the current slot pair
    assign addr_a = AW'(slot_reg);
    assign addr_b = AW'(slot_reg) + AW'(Half);

    // Two copies of the store, one per read address
    msp_ram #(.WIDTH(ByteW), .DEPTH(SERVO_COUNT)) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (addr_a),
        .rd_data (rd_a)
    );

    msp_ram #(.WIDTH(ByteW), .DEPTH(SERVO_COUNT)) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (addr_b),
        .rd_data (rd_b)
    );

    // Forward last cycle's write, unwritten entries read as center
    always_comb
    begin
        if (fwd_en_reg && (fwd_addr_reg == addr_a))
            pos_a = fwd_data_reg;
        else if (valid_reg[addr_a])
            pos_a = rd_a;
        else
            pos_a = CenterPos;
        if (fwd_en_reg && (fwd_addr_reg == addr_b))
            pos_b = fwd_data_reg;
        else if (valid_reg[addr_b])
            pos_b = rd_b;
        else
            pos_b = CenterPos;
    end

    // Group masks and start decode
    always_comb
    begin
        for (int i = 0; i < SERVO_COUNT; i++)
        begin
            mask_a[i]     = (i < Half);
            mask_b[i]     = (i >= Half) && (i < 2 * Half);
            start_mask[i] = (AW'(i) == addr_a) || (AW'(i) == addr_b);
        end
    end

    // Tick update: clear on compare match, start pair on wrap
    always_comb
    begin
        tick_next   = tick_reg;
        slot_next   = slot_reg;
        cmp_a_next  = cmp_a_reg;
        cmp_b_next  = cmp_b_reg;
        levels_next = levels_reg;
        if (tick_fire)
        begin
            tick_next = tick_reg + ByteW'(1);
            if (tick_next == cmp_a_reg)
                levels_next = levels_next & ~mask_a;
            if (tick_next == cmp_b_reg)
                levels_next = levels_next & ~mask_b;
            if (tick_next == '0)
            begin
                levels_next = levels_next | start_mask;
                cmp_a_next  = pos_a;
                cmp_b_next  = pos_b;
                slot_next   = (slot_reg == LastSlot) ? '0 : slot_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= '0;
            slot_reg   <= '0;
            cmp_a_reg  <= '0;
            cmp_b_reg  <= '0;
            levels_reg <= '0;
            valid_reg  <= '0;
            fwd_en_reg <= 1'b0;
        end
        else
        begin
            tick_reg   <= tick_next;
            slot_reg   <= slot_next;
            cmp_a_reg  <= cmp_a_next;
            cmp_b_reg  <= cmp_b_next;
            levels_reg <= levels_next;
            fwd_en_reg <= wr_en;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Forward data needs no reset
    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
    end

    // Slot stays inside the half count
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LastSlot)
        else $error("slot out of range");

    // Servos outside both groups never pulse
    a_outside_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (levels_reg & ~(mask_a | mask_b)) == '0)
        else $error("pulse on servo outside groups");

    // A wrap tick starts the slot pair
    a_wrap_start: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_fire && (tick_reg == '1)) |=> ((levels_reg & $past(start_mask)) != '0))
        else $error("wrap did not start slot pair");

endmodule

// File: rtl/multiplexed_servo_pulse_generator.sv
`timescale 1ns / 1ps
// Multiplexed servo pulse generator: 1 item per cycle sustained while out_ready
// holds, set by the single result register after the per-item update logic.
// The result is registered and valid in the cycle after the input transfer.
// Input is taken while the result register is empty or being drained.
// Reset (rst_n, async low) clears counters, levels and armed state, and restores
// the markers to 11 and 22; positions read as center until written.
// Depends on msp_pkg and submodules.
module multiplexed_servo_pulse_generator #(
    parameter int SERVO_COUNT = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [msp_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [msp_pkg::ByteW-1:0]    cfg_data,
    // Item input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [msp_pkg::ByteW-1:0]    data_byte,
    // Result output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [msp_pkg::PulseW-1:0]   servo_pulses,
    output logic                         byte_stored
);
    import msp_pkg::*;

    localparam int AW = $clog2(SERVO_COUNT);

    logic [ByteW-1:0]       arm_marker_reg;
    logic [ByteW-1:0]       disarm_marker_reg;
    logic                   out_valid_reg;
    logic [PulseW-1:0]      pulses_reg;
    logic                   stored_reg;

    logic                   in_fire, tick_fire, byte_fire;
    logic                   wr_en, stored;
    logic [AW-1:0]          wr_addr;
    logic [ByteW-1:0]       wr_data;
    logic [SERVO_COUNT-1:0] levels_next;
    logic [LevelExtW-1:0]   levels_ext;

    // Handshake: output register frees up on a downstream transfer
    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign tick_fire = in_fire && (cmd == CMD_TICK);
    assign byte_fire = in_fire && (cmd == CMD_BYTE);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_marker_reg    <= ArmMarkerRst;
            disarm_marker_reg <= DisarmMarkerRst;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ARM_MARKER:    arm_marker_reg    <= cfg_data;
                REG_DISARM_MARKER: disarm_marker_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    msp_loader #(.SERVO_COUNT(SERVO_COUNT)) u_loader (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_fire     (byte_fire),
        .data_byte     (data_byte),
        .arm_marker    (arm_marker_reg),
        .disarm_marker (disarm_marker_reg),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .stored        (stored)
    );

    msp_pulse #(.SERVO_COUNT(SERVO_COUNT)) u_pulse (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_fire   (tick_fire),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .levels_next (levels_next)
    );

    // Visible levels: low 24 servos, zero above the servo count
    assign levels_ext = LevelExtW'(levels_next);

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pulses_reg <= levels_ext[PulseW-1:0];
            stored_reg <= stored;
        end
    end

    assign out_valid    = out_valid_reg;
    assign servo_pulses = pulses_reg;
    assign byte_stored  = stored_reg;

    // Every accepted item yields a result next cycle
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
        else $error("accepted item produced no result");

    // A tick item never reports a stored byte
    a_tick_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> !byte_stored)
        else $error("tick reported a stored byte");

    // An empty result register always takes input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule
